>>> design/pose_to_camera_ray_basis_top_defines.svh
// assertion macros for the camera ray basis block
`ifndef POSE_TO_CAMERA_RAY_BASIS_TOP_DEFINES_SVH
`define POSE_TO_CAMERA_RAY_BASIS_TOP_DEFINES_SVH

// property that must hold at every edge outside reset
`define PRCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition at one edge implies a property at the next edge
`define PRCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/prcb_pkg.sv
// types, constants and helpers shared by the camera ray basis block
`default_nettype none

package prcb_pkg;

  // datapath widths
  localparam int ROT_W  = 34;   // rotation entry, scale 2^28
  localparam int AX_W   = 38;   // camera axis entry, scale 2^28
  localparam int NUM_W  = 56;   // axis times view scale
  localparam int N_W    = 58;   // divider numerator
  localparam int QB     = 47;   // quotient bits produced by the divider
  localparam int REM_W  = 18;   // divider remainder
  localparam int DIV_W  = 17;   // divider denominator
  localparam int DV_W   = 49;   // clamped row step, scale 2^28
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [35:0]     RotOne  = 36'sd268435456;
  localparam logic signed [DV_W-1:0] DvLimit = 49'sh400000000000;

  // configuration register reset values
  localparam logic [CFG_W-1:0] Mount0Rst = 64'h0000_0000_0000_4000;
  localparam logic [CFG_W-1:0] Mount1Rst = 64'h0000_0000_4000_0000;
  localparam logic [CFG_W-1:0] Mount2Rst = 64'h0000_4000_0000_0000;
  localparam logic [15:0]      ScaleRst  = 16'h2000;
  localparam logic [15:0]      AspectRst = 16'h1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOUNT0 = 3'd0,
    REG_MOUNT1 = 3'd1,
    REG_MOUNT2 = 3'd2,
    REG_SCALE  = 3'd3,
    REG_ASPECT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] cam_pos_x;
    logic signed [31:0] cam_pos_y;
    logic signed [31:0] cam_pos_z;
    logic signed [31:0] corner_ray_x;
    logic signed [31:0] corner_ray_y;
    logic signed [31:0] corner_ray_z;
    logic signed [31:0] column_step_x;
    logic signed [31:0] column_step_y;
    logic signed [31:0] column_step_z;
    logic signed [31:0] row_step_x;
    logic signed [31:0] row_step_y;
    logic signed [31:0] row_step_z;
  } ray_t;

  // live configuration seen by the back end
  typedef struct packed {
    logic [2:0][CFG_W-1:0] row;
    logic [15:0]           scale;
    logic [15:0]           aspect;
  } cfg_t;

  // entry of the queue between front and back
  typedef struct packed {
    logic [2:0][31:0]      pos;
    logic [8:0][ROT_W-1:0] rot;
  } mq_entry_t;

  // queue status seen by front, back and top
  typedef struct packed {
    logic full;
    logic empty;
  } mq_stat_t;

  // one stage of the row step divider with its carried payload
  typedef struct packed {
    logic [2:0][31:0]      cam;
    logic [2:0][AX_W-1:0]  fwd;
    logic [2:0][NUM_W-1:0] du;
    logic [2:0]            neg;
    logic [2:0]            big;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][QB-1:0]    ql;
  } div_slot_t;

  // saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> design/pose_to_camera_ray_basis_top.sv
// top level of the camera ray basis block: config registers and wiring
//
//   channel   handshake            payload
//   pose in   push / full          pose_i  (prcb_pkg::pose_t)
//   ray out   empty / pop          ray_o   (prcb_pkg::ray_t)
//   config    cfg_we_i, cfg_idx_i  cfg_wdata_i (64 bits)
//
// one pose per cycle sustained while rays are popped; each pose goes
// through the mount products and the 47-stage pipelined row step divider
// reset: asynchronous, active low; mount identity, scale 2.0, aspect 1.0
// a stalled result holds the whole back pipeline; the front keeps taking
// poses until the queue between front and back fills
`default_nettype none

`include "pose_to_camera_ray_basis_top_defines.svh"

module pose_to_camera_ray_basis_top #(
  parameter int QueueDepth = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire prcb_pkg::pose_t                   pose_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output prcb_pkg::ray_t                         ray_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [prcb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [prcb_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import prcb_pkg::*;

  cfg_t      cfg_q;
  mq_stat_t  mq_stat;
  mq_entry_t mq_wdata, mq_rdata;
  logic      mq_push, mq_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0] <= Mount0Rst;
      cfg_q.row[1] <= Mount1Rst;
      cfg_q.row[2] <= Mount2Rst;
      cfg_q.scale  <= ScaleRst;
      cfg_q.aspect <= AspectRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MOUNT0: cfg_q.row[0] <= cfg_wdata_i;
        REG_MOUNT1: cfg_q.row[1] <= cfg_wdata_i;
        REG_MOUNT2: cfg_q.row[2] <= cfg_wdata_i;
        REG_SCALE:  cfg_q.scale  <= cfg_wdata_i[15:0];
        REG_ASPECT: cfg_q.aspect <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // front end
  prcb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pose_i    (pose_i),
    .push      (push),
    .full      (full),
    .mq_stat_i (mq_stat),
    .mq_push_o (mq_push),
    .mq_data_o (mq_wdata)
  );

  // queue between front and back
  prcb_queue #(
    .DEPTH (QueueDepth),
    .T     (mq_entry_t)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mq_push),
    .data_i (mq_wdata),
    .pop_i  (mq_pop),
    .data_o (mq_rdata),
    .stat_o (mq_stat)
  );

  // back end
  prcb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .mq_stat_i (mq_stat),
    .mq_data_i (mq_rdata),
    .mq_pop_o  (mq_pop),
    .ray_o     (ray_o),
    .empty     (empty),
    .pop       (pop)
  );

  // internal queue checks
  `PRCB_ASSERT(a_pop_not_empty, !mq_pop || !mq_stat.empty, "back popped an empty queue")
  `PRCB_ASSERT(a_full_empty_excl, !(mq_stat.full && mq_stat.empty), "queue full and empty")
  `PRCB_ASSERT_NEXT(a_full_holds, mq_stat.full && !mq_pop, mq_stat.full, "queue lost an entry")

endmodule

`default_nettype wire

>>> design/prcb_front.sv
// front end: pose input register and rotation matrix from the quaternion
`default_nettype none

module prcb_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prcb_pkg::pose_t     pose_i,
  input  wire logic                push,
  output logic                     full,
  input  wire prcb_pkg::mq_stat_t  mq_stat_i,
  output logic                     mq_push_o,
  output prcb_pkg::mq_entry_t      mq_data_o
);
  import prcb_pkg::*;

  logic  in_v_q, in_v_d;
  pose_t pose_q;
  logic  load;

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [35:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  // handshake with the input side and the queue
  assign full      = in_v_q && mq_stat_i.full;
  assign mq_push_o = in_v_q && !mq_stat_i.full;
  assign load      = push && !full;

  always_comb begin
    in_v_d = in_v_q;
    if (load) begin
      in_v_d = 1'b1;
    end else if (mq_push_o) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pose_q <= pose_i;
    end
  end

  // quaternion products and rotation entries at scale 2^28
  always_comb begin
    xx = 32'(pose_q.quat_x) * 32'(pose_q.quat_x);
    yy = 32'(pose_q.quat_y) * 32'(pose_q.quat_y);
    zz = 32'(pose_q.quat_z) * 32'(pose_q.quat_z);
    xy = 32'(pose_q.quat_x) * 32'(pose_q.quat_y);
    xz = 32'(pose_q.quat_x) * 32'(pose_q.quat_z);
    yz = 32'(pose_q.quat_y) * 32'(pose_q.quat_z);
    wx = 32'(pose_q.quat_w) * 32'(pose_q.quat_x);
    wy = 32'(pose_q.quat_w) * 32'(pose_q.quat_y);
    wz = 32'(pose_q.quat_w) * 32'(pose_q.quat_z);
    r00 = RotOne - ((36'(yy) + 36'(zz)) <<< 1);
    r01 = (36'(xy) - 36'(wz)) <<< 1;
    r02 = (36'(xz) + 36'(wy)) <<< 1;
    r10 = (36'(xy) + 36'(wz)) <<< 1;
    r11 = RotOne - ((36'(xx) + 36'(zz)) <<< 1);
    r12 = (36'(yz) - 36'(wx)) <<< 1;
    r20 = (36'(xz) - 36'(wy)) <<< 1;
    r21 = (36'(yz) + 36'(wx)) <<< 1;
    r22 = RotOne - ((36'(xx) + 36'(yy)) <<< 1);
  end

  // queue entry, rotation row major
  always_comb begin
    mq_data_o.pos[0] = pose_q.pos_x;
    mq_data_o.pos[1] = pose_q.pos_y;
    mq_data_o.pos[2] = pose_q.pos_z;
    mq_data_o.rot[0] = ROT_W'(r00);
    mq_data_o.rot[1] = ROT_W'(r01);
    mq_data_o.rot[2] = ROT_W'(r02);
    mq_data_o.rot[3] = ROT_W'(r10);
    mq_data_o.rot[4] = ROT_W'(r11);
    mq_data_o.rot[5] = ROT_W'(r12);
    mq_data_o.rot[6] = ROT_W'(r20);
    mq_data_o.rot[7] = ROT_W'(r21);
    mq_data_o.rot[8] = ROT_W'(r22);
  end

endmodule

`default_nettype wire

>>> design/prcb_queue.sv
// short queue between front and back end
`default_nettype none

module prcb_queue #(
  parameter int  DEPTH = 4,
  parameter type T     = logic
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire T                   data_i,
  input  wire logic               pop_i,
  output T                        data_o,
  output prcb_pkg::mq_stat_t      stat_o
);
  import prcb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/prcb_back.sv
// back end: mount product, scaling, pipelined row step divider, result register
`default_nettype none

module prcb_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prcb_pkg::cfg_t      cfg_i,
  input  wire prcb_pkg::mq_stat_t  mq_stat_i,
  input  wire prcb_pkg::mq_entry_t mq_data_i,
  output logic                     mq_pop_o,
  output prcb_pkg::ray_t           ray_o,
  output logic                     empty,
  input  wire logic                pop
);
  import prcb_pkg::*;

  logic adv;

  // stage 0: matrix products
  logic              s0_v_q;
  logic signed [49:0] s0_prod_q [3][3][3];
  logic signed [49:0] s0_offp_q [3][3];
  logic signed [31:0] s0_pos_q  [3];
  logic signed [49:0] s0_prod_d [3][3][3];
  logic signed [49:0] s0_offp_d [3][3];

  // stage 1: sums
  logic              s1_v_q;
  logic signed [51:0] s1_acc_q [3][3];
  logic signed [55:0] s1_p36_q [3];

  // stage 2: rounded axes and camera position
  logic              s2_v_q;
  logic signed [AX_W-1:0] s2_ax_q [3][3];
  logic [31:0]            s2_cam_q [3];
  logic signed [AX_W-1:0] s2_ax_d [3][3];
  logic [31:0]            s2_cam_d [3];

  // stage 3: view scale products
  logic              s3_v_q;
  logic signed [NUM_W-1:0] s3_du_q  [3];
  logic signed [NUM_W-1:0] s3_num_q [3];
  logic signed [AX_W-1:0]  s3_fwd_q [3];
  logic [31:0]             s3_cam_q [3];

  // divider stages
  logic      [QB:0] slot_v_q;
  div_slot_t        slot_q [QB+1];
  div_slot_t        slot0_d;

  // end stage: row step and corner
  logic              e1_v_q;
  logic [31:0]             e1_cam_q    [3];
  logic signed [NUM_W-1:0] e1_du_q     [3];
  logic signed [63:0]      e1_corner_q [3];
  logic signed [DV_W-1:0]  e1_dv_q     [3];
  logic signed [63:0]      e1_corner_d [3];
  logic signed [DV_W-1:0]  e1_dv_d     [3];

  // result register
  logic out_v_q;
  ray_t out_q, out_d;

  logic [15:0]      asp_eff;
  logic [DIV_W-1:0] den;

  // one restoring step for all three rows
  function automatic div_slot_t div_step(input div_slot_t a, input logic [DIV_W-1:0] d);
    div_slot_t      b;
    logic [REM_W:0] t;
    b = a;
    for (int r = 0; r < 3; r++) begin
      t = {a.rem[r], a.ql[r][QB-1]};
      if (t >= {2'b00, d}) begin
        b.rem[r] = REM_W'(t - {2'b00, d});
        b.ql[r]  = {a.ql[r][QB-2:0], 1'b1};
      end else begin
        b.rem[r] = REM_W'(t);
        b.ql[r]  = {a.ql[r][QB-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  // pipeline moves unless a finished result is blocked
  assign adv      = !(e1_v_q && out_v_q && !pop);
  assign mq_pop_o = adv && !mq_stat_i.empty;

  // zero aspect counts as the smallest nonzero aspect
  assign asp_eff = (cfg_i.aspect == '0) ? 16'd1 : cfg_i.aspect;
  assign den     = {asp_eff, 1'b0};

  // products of rotation with mount and offset
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          s0_prod_d[r][i][c] = 50'($signed(mq_data_i.rot[3*r+i])) *
                               50'($signed(cfg_i.row[i][16*c +: 16]));
        end
        s0_offp_d[r][i] = 50'($signed(mq_data_i.rot[3*r+i])) *
                          50'($signed(cfg_i.row[i][63:48]));
      end
    end
  end

  // rounding of axes and camera position
  always_comb begin
    logic signed [63:0] t;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        t = (64'(s1_acc_q[r][c]) + 64'sd8192) >>> 14;
        s2_ax_d[r][c] = AX_W'(t);
      end
      t = (64'(s1_p36_q[r]) + 64'sd524288) >>> 20;
      s2_cam_d[r] = sat32(t);
    end
  end

  // divider setup: sign, magnitude, overflow check
  always_comb begin
    logic signed [N_W-1:0] n;
    logic [N_W-1:0]        mag;
    slot0_d = '0;
    for (int r = 0; r < 3; r++) begin
      n = (N_W'(s3_num_q[r]) <<< 1) + N_W'($signed({1'b0, asp_eff}));
      mag = (n < 0) ? N_W'(-n) : N_W'(n);
      slot0_d.cam[r] = s3_cam_q[r];
      slot0_d.fwd[r] = s3_fwd_q[r];
      slot0_d.du[r]  = s3_du_q[r];
      slot0_d.neg[r] = (n < 0);
      slot0_d.big[r] = ({{(64-N_W){1'b0}}, mag} >= {den, {QB{1'b0}}});
      slot0_d.rem[r] = REM_W'(mag[N_W-1:QB]);
      slot0_d.ql[r]  = mag[QB-1:0];
    end
  end

  // floor quotient, clamp and corner sum
  always_comb begin
    logic signed [DV_W-1:0] qx;
    logic signed [DV_W-1:0] dv;
    for (int r = 0; r < 3; r++) begin
      qx = $signed({2'b00, slot_q[QB].ql[r]});
      if (slot_q[QB].neg[r] && (slot_q[QB].rem[r] != '0)) begin
        qx = qx + 49'sd1;
      end
      if (slot_q[QB].neg[r]) begin
        qx = -qx;
      end
      if (slot_q[QB].big[r]) begin
        dv = slot_q[QB].neg[r] ? -DvLimit : DvLimit;
      end else if (qx > DvLimit) begin
        dv = DvLimit;
      end else if (qx < -DvLimit) begin
        dv = -DvLimit;
      end else begin
        dv = qx;
      end
      e1_dv_d[r]     = dv;
      e1_corner_d[r] = (64'($signed(slot_q[QB].fwd[r])) <<< 13)
                     - 64'($signed(slot_q[QB].du[r]))
                     + (64'(dv) <<< 12);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      slot_v_q <= '0;
      e1_v_q   <= 1'b0;
    end else if (adv) begin
      s0_v_q      <= mq_pop_o;
      s1_v_q      <= s0_v_q;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      slot_v_q[0] <= s3_v_q;
      for (int s = 1; s <= QB; s++) begin
        slot_v_q[s] <= slot_v_q[s-1];
      end
      e1_v_q <= slot_v_q[QB];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_prod_q <= s0_prod_d;
      s0_offp_q <= s0_offp_d;
      for (int r = 0; r < 3; r++) begin
        s0_pos_q[r] <= $signed(mq_data_i.pos[r]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_acc_q[r][c] <= 52'(s0_prod_q[r][0][c]) + 52'(s0_prod_q[r][1][c])
                          + 52'(s0_prod_q[r][2][c]);
        end
        s1_p36_q[r] <= (56'(s0_pos_q[r]) <<< 20) + 56'(s0_offp_q[r][0])
                     + 56'(s0_offp_q[r][1]) + 56'(s0_offp_q[r][2]);
      end
      s2_ax_q  <= s2_ax_d;
      s2_cam_q <= s2_cam_d;
      for (int r = 0; r < 3; r++) begin
        s3_du_q[r]  <= NUM_W'(-(39'(s2_ax_q[r][1]))) *
                       NUM_W'($signed({1'b0, cfg_i.scale}));
        s3_num_q[r] <= NUM_W'(s2_ax_q[r][2]) * NUM_W'($signed({1'b0, cfg_i.scale}));
        s3_fwd_q[r] <= s2_ax_q[r][0];
        s3_cam_q[r] <= s2_cam_q[r];
      end
      slot_q[0] <= slot0_d;
      for (int s = 1; s <= QB; s++) begin
        slot_q[s] <= div_step(slot_q[s-1], den);
      end
      for (int r = 0; r < 3; r++) begin
        e1_cam_q[r]    <= slot_q[QB].cam[r];
        e1_du_q[r]     <= $signed(slot_q[QB].du[r]);
        e1_corner_q[r] <= e1_corner_d[r];
        e1_dv_q[r]     <= e1_dv_d[r];
      end
    end
  end

  // final rounding and saturation
  always_comb begin
    logic signed [63:0] c0, c1, c2, u0, u1, u2, v0, v1, v2;
    c0 = (e1_corner_q[0] + 64'sd16777216) >>> 25;
    c1 = (e1_corner_q[1] + 64'sd16777216) >>> 25;
    c2 = (e1_corner_q[2] + 64'sd16777216) >>> 25;
    u0 = (64'(e1_du_q[0]) + 64'sd8388608) >>> 24;
    u1 = (64'(e1_du_q[1]) + 64'sd8388608) >>> 24;
    u2 = (64'(e1_du_q[2]) + 64'sd8388608) >>> 24;
    v0 = (-64'(e1_dv_q[0]) + 64'sd2048) >>> 12;
    v1 = (-64'(e1_dv_q[1]) + 64'sd2048) >>> 12;
    v2 = (-64'(e1_dv_q[2]) + 64'sd2048) >>> 12;
    out_d.cam_pos_x     = e1_cam_q[0];
    out_d.cam_pos_y     = e1_cam_q[1];
    out_d.cam_pos_z     = e1_cam_q[2];
    out_d.corner_ray_x  = sat32(c0);
    out_d.corner_ray_y  = sat32(c1);
    out_d.corner_ray_z  = sat32(c2);
    out_d.column_step_x = sat32(u0);
    out_d.column_step_y = sat32(u1);
    out_d.column_step_z = sat32(u2);
    out_d.row_step_x    = sat32(v0);
    out_d.row_step_y    = sat32(v1);
    out_d.row_step_z    = sat32(v2);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && e1_v_q) begin
      out_v_q <= 1'b1;
    end else if (pop && out_v_q) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && e1_v_q) begin
      out_q <= out_d;
    end
  end

  assign empty = !out_v_q;
  assign ray_o = out_q;

endmodule

`default_nettype wire

>>> tb/pose_to_camera_ray_basis_top_tb.sv
// self-checking testbench for the camera ray basis block
`default_nettype none

module pose_to_camera_ray_basis_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prcb_pkg::*;

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 80;
  localparam int RandomPoses = 650;
  localparam logic [CFG_IDX_W-1:0] RegUnused = 3'd7;

  // directed pose with an optional hand-computed ray
  typedef struct {
    pose_t pose;
    bit    typed;
    ray_t  ray;
  } pose_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  pose_t                pose_i;
  logic                 empty;
  logic                 pop;
  ray_t                 ray_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  // shadow of the configuration registers
  logic [CFG_W-1:0] mount_rows [3];
  logic [15:0]      view_scale;
  logic [15:0]      aspect;

  ray_t pending_rays [$];
  int   mismatches;
  int   idle_cycles;
  int   pop_mode;
  bit   gapless;
  pose_row_t pose_table [$];

  pose_to_camera_ray_basis_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .pose_i(pose_i),
    .empty(empty), .pop(pop), .ray_o(ray_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // round half up after dropping s bits
  function automatic longint round_down_bits(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // camera position and ray basis for one pose under the shadow config
  function automatic ray_t predict_ray(pose_t p);
    longint w, x, y, z, one, vs, asp, acc, p36;
    longint fwd, rgt, up, du40, num, dv28, corner41;
    longint rot [3][3];
    longint mnt [3][3];
    longint off [3];
    longint ax [3][3];
    longint pos [3];
    logic [11:0][31:0] o;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    w = p.quat_w;
    x = p.quat_x;
    y = p.quat_y;
    z = p.quat_z;
    one = 64'sd1 <<< 28;
    rot[0][0] = one - 2 * (y * y + z * z);
    rot[0][1] = 2 * (x * y - w * z);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][0] = 2 * (x * y + w * z);
    rot[1][1] = one - 2 * (x * x + z * z);
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][0] = 2 * (x * z - w * y);
    rot[2][1] = 2 * (y * z + w * x);
    rot[2][2] = one - 2 * (x * x + y * y);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mnt[r][c] = longint'($signed(mount_rows[r][16*c +: 16]));
      end
      off[r] = longint'($signed(mount_rows[r][63:48]));
    end
    vs  = longint'(view_scale);
    asp = (aspect == 16'd0) ? 64'sd1 : longint'(aspect);
    for (int r = 0; r < 3; r++) begin
      p36 = pos[r] * (64'sd1 <<< 20);
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += rot[r][i] * mnt[i][c];
        ax[r][c] = round_down_bits(acc, 14);
      end
      for (int i = 0; i < 3; i++) p36 += rot[r][i] * off[i];
      o[11 - r] = clip32(round_down_bits(p36, 20));
    end
    for (int r = 0; r < 3; r++) begin
      fwd  = ax[r][0];
      rgt  = -ax[r][1];
      up   = ax[r][2];
      du40 = rgt * vs;
      num  = 2 * up * vs + asp;
      // floor division by a positive divisor
      dv28 = num / (2 * asp);
      if ((num % (2 * asp)) != 0 && num < 0) dv28 -= 1;
      if (dv28 > (64'sd1 <<< 46)) dv28 = 64'sd1 <<< 46;
      if (dv28 < -(64'sd1 <<< 46)) dv28 = -(64'sd1 <<< 46);
      corner41 = fwd * (64'sd1 <<< 13) - du40 + dv28 * (64'sd1 <<< 12);
      o[8 - r] = clip32(round_down_bits(corner41, 25));
      o[5 - r] = clip32(round_down_bits(du40, 24));
      o[2 - r] = clip32(round_down_bits(-dv28, 12));
    end
    return ray_t'(o);
  endfunction

  // random quaternion: near-unit, raw bits, or axis extremes
  function automatic pose_t random_pose();
    pose_t p;
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(0, 7);
    p.pos_x = (kind < 5) ? $signed($urandom_range(0, 8388607)) - 4194304 : $urandom;
    p.pos_y = (kind < 5) ? $signed($urandom_range(0, 8388607)) - 4194304 : $urandom;
    p.pos_z = (kind < 5) ? $signed($urandom_range(0, 8388607)) - 4194304 : $urandom;
    if (kind < 5) begin
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 0.001;
      p.quat_w = $rtoi(a / n * 16384.0);
      p.quat_x = $rtoi(b / n * 16384.0);
      p.quat_y = $rtoi(c / n * 16384.0);
      p.quat_z = $rtoi(d / n * 16384.0);
    end else if (kind < 7) begin
      p.quat_w = $urandom;
      p.quat_x = $urandom;
      p.quat_y = $urandom;
      p.quat_z = $urandom;
    end else begin
      p.quat_w = 16'(($urandom_range(0, 2) - 1) * 16384);
      p.quat_x = 16'(($urandom_range(0, 2) - 1) * 16384);
      p.quat_y = 16'(($urandom_range(0, 2) - 1) * 16384);
      p.quat_z = 16'(($urandom_range(0, 2) - 1) * 16384);
    end
    return p;
  endfunction

  // one pose transaction, held until the block takes it
  task automatic send_pose(pose_t p, bit typed, ray_t ray);
    push   <= 1'b1;
    pose_i <= p;
    do @(posedge clk_i); while (full);
    pending_rays.push_back(typed ? ray : predict_ray(p));
  endtask

  task automatic pause_sender(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // wait for the block to drain before touching the registers
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_rays.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MOUNT0: mount_rows[0] = data;
      REG_MOUNT1: mount_rows[1] = data;
      REG_MOUNT2: mount_rows[2] = data;
      REG_SCALE:  view_scale    = data[15:0];
      REG_ASPECT: aspect        = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_config(logic [CFG_W-1:0] m0, logic [CFG_W-1:0] m1,
                              logic [CFG_W-1:0] m2, logic [15:0] vs,
                              logic [15:0] asp);
    drain();
    write_reg(REG_MOUNT0, m0);
    write_reg(REG_MOUNT1, m1);
    write_reg(REG_MOUNT2, m2);
    write_reg(REG_SCALE, {48'h0, vs});
    write_reg(REG_ASPECT, {48'h0, asp});
    // unknown index must leave every register alone
    write_reg(RegUnused, {$urandom, $urandom});
  endtask

  // random poses sent in bursts, with gaps unless gapless is set
  task automatic random_phase(int count);
    ray_t none;
    int burst;
    none  = '0;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (!gapless) pause_sender($urandom_range(1, 8));
      end
      send_pose(random_pose(), 1'b0, none);
      burst--;
    end
  endtask

  function automatic pose_t make_pose(int px, int py, int pz,
                                      int qw, int qx, int qy, int qz);
    pose_t p;
    p.pos_x  = px;
    p.pos_y  = py;
    p.pos_z  = pz;
    p.quat_w = 16'(qw);
    p.quat_x = 16'(qx);
    p.quat_y = 16'(qy);
    p.quat_z = 16'(qz);
    return p;
  endfunction

  task automatic add_row(pose_t p, bit typed, ray_t ray);
    pose_row_t row;
    row.pose  = p;
    row.typed = typed;
    row.ray   = ray;
    pose_table.push_back(row);
  endtask

  // stimulus
  initial begin
    ray_t id_ray;
    ray_t none;
    none        = '0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    pose_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MOUNT0;
    cfg_wdata_i = '0;
    gapless     = 1'b0;
    mount_rows[0] = Mount0Rst;
    mount_rows[1] = Mount1Rst;
    mount_rows[2] = Mount2Rst;
    view_scale    = ScaleRst;
    aspect        = AspectRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity pose at reset config: unit corner, steps of two
    id_ray = '{cam_pos_x: 0, cam_pos_y: 0, cam_pos_z: 0,
               corner_ray_x: 65536, corner_ray_y: 65536, corner_ray_z: 65536,
               column_step_x: 0, column_step_y: -131072, column_step_z: 0,
               row_step_x: 0, row_step_y: 0, row_step_z: -131072};
    add_row(make_pose(0, 0, 0, 16384, 0, 0, 0), 1'b1, id_ray);
    id_ray.cam_pos_x = 32'h7fff_ffff;
    id_ray.cam_pos_y = 32'h8000_0000;
    id_ray.cam_pos_z = -1;
    add_row(make_pose(32'h7fff_ffff, 32'h8000_0000, -1, 16384, 0, 0, 0), 1'b1, id_ray);
    add_row(make_pose(0, 0, 0, -16384, 0, 0, 0), 1'b0, none);
    add_row(make_pose(65536, -65536, 0, 0, 16384, 0, 0), 1'b0, none);
    add_row(make_pose(0, 0, 0, 0, 0, 16384, 0), 1'b0, none);
    add_row(make_pose(0, 0, 0, 0, 0, 0, 16384), 1'b0, none);
    add_row(make_pose(0, 0, 0, 0, 0, 0, -16384), 1'b0, none);
    add_row(make_pose(12345, 6789, -1011, 11585, 11585, 0, 0), 1'b0, none);
    // non-unit and out-of-range quaternions
    add_row(make_pose(0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(make_pose(0, 0, 0, 32767, 32767, 32767, 32767), 1'b0, none);
    add_row(make_pose(0, 0, 0, -32768, -32768, -32768, -32768), 1'b0, none);
    add_row(make_pose(-1, -1, -1, 16384, 16384, 16384, 16384), 1'b0, none);
    add_row(make_pose(32'h8000_0000, 32'h7fff_ffff, 0, -16384, 16384, -16384, 16384),
            1'b0, none);
    foreach (pose_table[i]) begin
      send_pose(pose_table[i].pose, pose_table[i].typed, pose_table[i].ray);
    end
    random_phase(100);

    // offset mount, wide view, tall image
    write_config(64'h0100_0000_0000_4000, 64'hff00_0000_4000_0000,
                 64'h0080_4000_0000_0000, 16'hffff, 16'h0001);
    drain();
    send_pose(make_pose(0, 0, 0, 16384, 0, 0, 0), 1'b0, none);
    send_pose(make_pose(32'h7fff_ffff, 0, 0, 0, 0, 0, 16384), 1'b0, none);
    random_phase(90);

    // zero scale and zero aspect
    write_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 16'h0000, 16'h0000);
    gapless = 1'b1;
    random_phase(90);

    // every config bit set
    write_config('1, '1, '1, 16'hffff, 16'hffff);
    random_phase(90);
    gapless = 1'b0;

    // every config bit clear except a legal aspect
    write_config('0, '0, '0, 16'h0000, 16'h0001);
    random_phase(60);

    // random mounts in several settings
    for (int ph = 0; ph < 4; ph++) begin
      write_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom), 16'($urandom_range(1, 65535)));
      random_phase(RandomPoses / 16);
    end

    // back to the reset values
    write_config(Mount0Rst, Mount1Rst, Mount2Rst, ScaleRst, AspectRst);
    random_phase(40);

    push <= 1'b0;
    do @(posedge clk_i); while (pending_rays.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    mismatches += pending_rays.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stall pattern, switched to a random mode at random times
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_mode <= 0;
    end else begin
      if ($urandom_range(0, 255) == 0) pop_mode <= $urandom_range(0, 3);
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= ($urandom_range(0, 9) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result check against the oldest expected ray
  always @(posedge clk_i) begin
    logic [11:0][31:0] got;
    logic [11:0][31:0] want;
    if (rst_ni && pop && !empty) begin
      got = ray_o;
      if (pending_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ray transaction %h", got);
      end else begin
        want = pending_rays.pop_front();
        for (int f = 11; f >= 0; f--) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ray field %0d (0 = cam_pos_x): expected %h got %h",
                       11 - f, want[f], got[f]);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) ||
        (pending_rays.size() == 0 && !push)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial mismatches = 0;
  initial idle_cycles = 0;

endmodule

`default_nettype wire
